// ----- rtl/core/pdre_pkg.sv -----
package pdre_pkg;

  // default widths of the absolute position fields
  parameter int unsigned LINE_BITS_DEF = 20;
  parameter int unsigned COL_BITS_DEF  = 12;

  // fixed record field widths
  parameter int unsigned LINE_STEP_W = 16;
  parameter int unsigned COL_STEP_W  = 8;
  parameter int unsigned REF_W       = 8;
  parameter int unsigned TARGET_W    = 32;

  // largest step one record can carry
  parameter int unsigned MAX_LINE_STEP = 32'h0000_7fff;
  parameter int unsigned MAX_COL_STEP  = 32'h0000_007f;

  // split records per input before the rest is forced into the final record
  parameter int unsigned MAX_SPLITS = 32;

  // input func codes
  parameter logic FUNC_SET_POS = 1'b0;
  parameter logic FUNC_ADD_REF = 1'b1;

  // record kinds
  parameter logic KIND_DELTA = 1'b0;
  parameter logic KIND_USAGE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF_LINE,
    ST_DIFF_COL,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/core/pdre_absdiff.sv -----
// Shared magnitude/sign subtractor: mag = |a - b|, neg = (a < b).
module pdre_absdiff #(
  parameter int unsigned W = pdre_pkg::LINE_BITS_DEF
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] mag,
  output logic         neg
);

  logic [W:0] diff;

  assign diff = {1'b0, a} - {1'b0, b};
  assign neg  = diff[W];
  assign mag  = diff[W] ? (W'(0) - diff[W-1:0]) : diff[W-1:0];

endmodule

// ----- rtl/core/position_delta_record_encoder_core.sv -----
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   func, line, line_keep, col, col_keep, ref_kind, target
// out      out  out_valid / out_ready kind, col_step, line_step, ref_out, target_out, last
//
// An item produces N records (1..33) in these steps: an accept in the idle state, the
// line and then the column difference through the single shared subtractor, then one
// record per cycle loaded into the output register while out_ready is high.
// Output stalls hold the sequencer in the emit state; in_ready is high only when idle.
// rst_n (synchronous) clears the sequencer, the output valid and the stored position.
module position_delta_record_encoder_core #(
  parameter int unsigned LINE_BITS = pdre_pkg::LINE_BITS_DEF,
  parameter int unsigned COL_BITS  = pdre_pkg::COL_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // input channel
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     in_func,
  input  logic [LINE_BITS-1:0]                     in_line,
  input  logic                                     in_line_keep,
  input  logic [COL_BITS-1:0]                      in_col,
  input  logic                                     in_col_keep,
  input  logic [pdre_pkg::REF_W-1:0]               in_ref_kind,
  input  logic [pdre_pkg::TARGET_W-1:0]            in_target,
  // result channel
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     out_kind,
  output logic signed [pdre_pkg::COL_STEP_W-1:0]   out_col_step,
  output logic signed [pdre_pkg::LINE_STEP_W-1:0]  out_line_step,
  output logic [pdre_pkg::REF_W-1:0]               out_ref_out,
  output logic [pdre_pkg::TARGET_W-1:0]            out_target_out,
  output logic                                     out_last
);

  localparam int unsigned DW    = (LINE_BITS > COL_BITS) ? LINE_BITS : COL_BITS;
  localparam int unsigned CNT_W = $clog2(pdre_pkg::MAX_SPLITS + 1);
  localparam int unsigned LSW   = pdre_pkg::LINE_STEP_W;
  localparam int unsigned CSW   = pdre_pkg::COL_STEP_W;

  localparam logic [LINE_BITS-1:0] LINE_MAX = LINE_BITS'(pdre_pkg::MAX_LINE_STEP);
  localparam logic [COL_BITS-1:0]  COL_MAX  = COL_BITS'(pdre_pkg::MAX_COL_STEP);

  // sequencer
  pdre_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // stored position
  logic [LINE_BITS-1:0] cur_line_r, cur_line_nxt;
  logic [COL_BITS-1:0]  cur_col_r, cur_col_nxt;

  // captured input beat
  logic                          func_r;
  logic [LINE_BITS-1:0]          line_r;
  logic                          line_keep_r;
  logic [COL_BITS-1:0]           col_r;
  logic                          col_keep_r;
  logic [pdre_pkg::REF_W-1:0]    ref_r;
  logic [pdre_pkg::TARGET_W-1:0] target_r;

  // remaining magnitudes and signs
  logic [LINE_BITS-1:0] dline_r, dline_nxt;
  logic [COL_BITS-1:0]  dcol_r, dcol_nxt;
  logic                 lneg_r, lneg_nxt;
  logic                 cneg_r, cneg_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_kind_nxt;
  logic signed [CSW-1:0]         out_col_step_r, out_col_step_nxt;
  logic signed [LSW-1:0]         out_line_step_r, out_line_step_nxt;
  logic [pdre_pkg::REF_W-1:0]    out_ref_r, out_ref_nxt;
  logic [pdre_pkg::TARGET_W-1:0] out_target_r, out_target_nxt;
  logic                          out_last_r, out_last_nxt;

  // shared subtractor, line first then column
  logic [DW-1:0] sub_a, sub_b, sub_mag;
  logic          sub_neg;

  pdre_absdiff #(
    .W(DW)
  ) u_absdiff (
    .a  (sub_a),
    .b  (sub_b),
    .mag(sub_mag),
    .neg(sub_neg)
  );

  always_comb begin
    if (state_r == pdre_pkg::ST_DIFF_COL) begin
      sub_a = DW'(col_r);
      sub_b = DW'(cur_col_r);
    end else begin
      sub_a = DW'(line_r);
      sub_b = DW'(cur_line_r);
    end
  end

  // record formation
  logic                 line_big, col_big, do_split;
  logic [LINE_BITS-1:0] line_mag;
  logic [COL_BITS-1:0]  col_mag;
  logic [LSW-1:0]       line_mag_lo;
  logic [CSW-1:0]       col_mag_lo;
  logic                 emit_go;

  assign line_big = dline_r > LINE_MAX;
  assign col_big  = dcol_r > COL_MAX;
  assign do_split = (line_big || col_big) && (cnt_r < CNT_W'(pdre_pkg::MAX_SPLITS));
  // a split record clamps each coordinate that exceeds its max to that max; the final one takes the rest
  assign line_mag    = (do_split && line_big) ? LINE_MAX : dline_r;
  assign col_mag     = (do_split && col_big) ? COL_MAX : dcol_r;
  assign line_mag_lo = line_mag[LSW-1:0];
  assign col_mag_lo  = col_mag[CSW-1:0];
  assign emit_go     = (state_r == pdre_pkg::ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    cur_line_nxt      = cur_line_r;
    cur_col_nxt       = cur_col_r;
    dline_nxt         = dline_r;
    dcol_nxt          = dcol_r;
    lneg_nxt          = lneg_r;
    cneg_nxt          = cneg_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_kind_nxt      = out_kind_r;
    out_col_step_nxt  = out_col_step_r;
    out_line_step_nxt = out_line_step_r;
    out_ref_nxt       = out_ref_r;
    out_target_nxt    = out_target_r;
    out_last_nxt      = out_last_r;

    unique case (state_r)
      pdre_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pdre_pkg::ST_DIFF_LINE;
        end
      end
      pdre_pkg::ST_DIFF_LINE: begin
        cnt_nxt = '0;
        if (line_keep_r) begin
          dline_nxt = '0;
          lneg_nxt  = 1'b0;
        end else begin
          dline_nxt    = sub_mag[LINE_BITS-1:0];
          lneg_nxt     = sub_neg;
          cur_line_nxt = line_r;
        end
        state_nxt = pdre_pkg::ST_DIFF_COL;
      end
      pdre_pkg::ST_DIFF_COL: begin
        if (col_keep_r) begin
          dcol_nxt = '0;
          cneg_nxt = 1'b0;
        end else begin
          dcol_nxt    = sub_mag[COL_BITS-1:0];
          cneg_nxt    = sub_neg;
          cur_col_nxt = col_r;
        end
        state_nxt = pdre_pkg::ST_EMIT;
      end
      pdre_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt     = 1'b1;
          out_line_step_nxt = lneg_r ? $signed(LSW'(0) - line_mag_lo) : $signed(line_mag_lo);
          out_col_step_nxt  = cneg_r ? $signed(CSW'(0) - col_mag_lo) : $signed(col_mag_lo);
          if (do_split) begin
            out_kind_nxt   = pdre_pkg::KIND_DELTA;
            out_ref_nxt    = '0;
            out_target_nxt = '0;
            out_last_nxt   = 1'b0;
            dline_nxt      = dline_r - line_mag;
            dcol_nxt       = dcol_r - col_mag;
            cnt_nxt        = cnt_r + CNT_W'(1);
          end else begin
            out_last_nxt = 1'b1;
            state_nxt    = pdre_pkg::ST_IDLE;
            if (func_r == pdre_pkg::FUNC_ADD_REF) begin
              out_kind_nxt   = pdre_pkg::KIND_USAGE;
              out_ref_nxt    = ref_r;
              out_target_nxt = target_r;
            end else begin
              out_kind_nxt   = pdre_pkg::KIND_DELTA;
              out_ref_nxt    = '0;
              out_target_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = pdre_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdre_pkg::ST_IDLE;
      cnt_r       <= '0;
      cur_line_r  <= '0;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_line_r  <= cur_line_nxt;
      cur_col_r   <= cur_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r      <= in_func;
      line_r      <= in_line;
      line_keep_r <= in_line_keep;
      col_r       <= in_col;
      col_keep_r  <= in_col_keep;
      ref_r       <= in_ref_kind;
      target_r    <= in_target;
    end
    dline_r         <= dline_nxt;
    dcol_r          <= dcol_nxt;
    lneg_r          <= lneg_nxt;
    cneg_r          <= cneg_nxt;
    out_kind_r      <= out_kind_nxt;
    out_col_step_r  <= out_col_step_nxt;
    out_line_step_r <= out_line_step_nxt;
    out_ref_r       <= out_ref_nxt;
    out_target_r    <= out_target_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign in_ready       = (state_r == pdre_pkg::ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_col_step   = out_col_step_r;
  assign out_line_step  = out_line_step_r;
  assign out_ref_out    = out_ref_r;
  assign out_target_out = out_target_r;
  assign out_last       = out_last_r;

endmodule

// ----- bench/pdre_record_check.sv -----
`timescale 1ns / 100ps

module pdre_record_check #(
  parameter int unsigned LINE_BITS = pdre_pkg::LINE_BITS_DEF,
  parameter int unsigned COL_BITS  = pdre_pkg::COL_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  input  logic                                     in_ready,
  input  logic                                     in_func,
  input  logic [LINE_BITS-1:0]                     in_line,
  input  logic                                     in_line_keep,
  input  logic [COL_BITS-1:0]                      in_col,
  input  logic                                     in_col_keep,
  input  logic [pdre_pkg::REF_W-1:0]               in_ref_kind,
  input  logic [pdre_pkg::TARGET_W-1:0]            in_target,
  input  logic                                     out_valid,
  input  logic                                     out_ready,
  input  logic                                     out_kind,
  input  logic signed [pdre_pkg::COL_STEP_W-1:0]   out_col_step,
  input  logic signed [pdre_pkg::LINE_STEP_W-1:0]  out_line_step,
  input  logic [pdre_pkg::REF_W-1:0]               out_ref_out,
  input  logic [pdre_pkg::TARGET_W-1:0]            out_target_out,
  input  logic                                     out_last,
  output int                                       mismatches,
  output int                                       pending,
  output int                                       records_seen
);

  typedef struct {
    logic                                    kind;
    logic signed [pdre_pkg::COL_STEP_W-1:0]  col_step;
    logic signed [pdre_pkg::LINE_STEP_W-1:0] line_step;
    logic [pdre_pkg::REF_W-1:0]              ref_out;
    logic [pdre_pkg::TARGET_W-1:0]           target_out;
    logic                                    last;
  } pos_record_t;

  pos_record_t          expected_records[$];
  logic [LINE_BITS-1:0] pos_line;
  logic [COL_BITS-1:0]  pos_col;

  function automatic logic [31:0] apply_sign(logic [31:0] mag, logic neg);
    return neg ? (32'd0 - mag) : mag;
  endfunction

  // Update the stored position and queue the records one beat produces.
  function automatic void predict_records(logic func, logic [LINE_BITS-1:0] line,
                                          logic line_keep, logic [COL_BITS-1:0] col,
                                          logic col_keep, logic [pdre_pkg::REF_W-1:0] ref_kind,
                                          logic [pdre_pkg::TARGET_W-1:0] target);
    logic [31:0] line_rest, col_rest, line_part, col_part, line_val, col_val;
    logic        line_neg, col_neg;
    int          splits;
    pos_record_t rec;
    line_rest = '0;
    col_rest  = '0;
    line_neg  = 1'b0;
    col_neg   = 1'b0;
    splits    = 0;
    if (!line_keep) begin
      if (line >= pos_line) begin
        line_rest = 32'(line - pos_line);
      end else begin
        line_rest = 32'(pos_line - line);
        line_neg  = 1'b1;
      end
      pos_line = line;
    end
    if (!col_keep) begin
      if (col >= pos_col) begin
        col_rest = 32'(col - pos_col);
      end else begin
        col_rest = 32'(pos_col - col);
        col_neg  = 1'b1;
      end
      pos_col = col;
    end
    while ((line_rest > pdre_pkg::MAX_LINE_STEP || col_rest > pdre_pkg::MAX_COL_STEP) &&
           splits < pdre_pkg::MAX_SPLITS) begin
      if (line_rest > pdre_pkg::MAX_LINE_STEP) begin
        line_part = pdre_pkg::MAX_LINE_STEP;
        line_rest = line_rest - pdre_pkg::MAX_LINE_STEP;
      end else begin
        line_part = line_rest;
        line_rest = '0;
      end
      if (col_rest > pdre_pkg::MAX_COL_STEP) begin
        col_part = pdre_pkg::MAX_COL_STEP;
        col_rest = col_rest - pdre_pkg::MAX_COL_STEP;
      end else begin
        col_part = col_rest;
        col_rest = '0;
      end
      line_val       = apply_sign(line_part, line_neg);
      col_val        = apply_sign(col_part, col_neg);
      rec.kind       = pdre_pkg::KIND_DELTA;
      rec.col_step   = col_val[pdre_pkg::COL_STEP_W-1:0];
      rec.line_step  = line_val[pdre_pkg::LINE_STEP_W-1:0];
      rec.ref_out    = '0;
      rec.target_out = '0;
      rec.last       = 1'b0;
      expected_records.push_back(rec);
      splits++;
    end
    // closing record carries the remainder; usage records also carry ref and target
    line_val      = apply_sign(line_rest, line_neg);
    col_val       = apply_sign(col_rest, col_neg);
    rec.col_step  = col_val[pdre_pkg::COL_STEP_W-1:0];
    rec.line_step = line_val[pdre_pkg::LINE_STEP_W-1:0];
    rec.last      = 1'b1;
    if (func == pdre_pkg::FUNC_ADD_REF) begin
      rec.kind       = pdre_pkg::KIND_USAGE;
      rec.ref_out    = ref_kind;
      rec.target_out = target;
    end else begin
      rec.kind       = pdre_pkg::KIND_DELTA;
      rec.ref_out    = '0;
      rec.target_out = '0;
    end
    expected_records.push_back(rec);
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pos_record_t exp_rec;
    if (!rst_n) begin
      pos_line = '0;
      pos_col  = '0;
      expected_records.delete();
      mismatches   = 0;
      records_seen = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_records(in_func, in_line, in_line_keep, in_col, in_col_keep,
                        in_ref_kind, in_target);
      end
      if (out_valid && out_ready) begin
        records_seen++;
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record kind %0d col_step %0d line_step %0d last %0d",
                   $time, out_kind, out_col_step, out_line_step, out_last);
          mismatches++;
        end else begin
          exp_rec = expected_records.pop_front();
          check_field("kind", exp_rec.kind, out_kind);
          check_field("col_step", exp_rec.col_step, out_col_step);
          check_field("line_step", exp_rec.line_step, out_line_step);
          check_field("ref_out", exp_rec.ref_out, out_ref_out);
          check_field("target_out", exp_rec.target_out, out_target_out);
          check_field("last", exp_rec.last, out_last);
        end
      end
    end
    pending = expected_records.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LINE_BITS = pdre_pkg::LINE_BITS_DEF;
  localparam int unsigned COL_BITS  = pdre_pkg::COL_BITS_DEF;
  localparam int          LINE_MAX  = (1 << LINE_BITS) - 1;
  localparam int          COL_MAX   = (1 << COL_BITS) - 1;
  localparam int          RANDOM_BEATS   = 230;
  // longest legal quiet stretch is a sender gap plus pipeline fill plus a
  // capped receiver stall; this limit is far beyond it
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_LOW_RUN    = 8;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_t;

  logic                    clk;
  logic                    rst_n        = 1'b0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic                    in_func      = pdre_pkg::FUNC_SET_POS;
  logic [LINE_BITS-1:0]    in_line      = '0;
  logic                    in_line_keep = 1'b0;
  logic [COL_BITS-1:0]     in_col       = '0;
  logic                    in_col_keep  = 1'b0;
  logic [pdre_pkg::REF_W-1:0]    in_ref_kind  = '0;
  logic [pdre_pkg::TARGET_W-1:0] in_target    = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic                    out_kind;
  logic signed [pdre_pkg::COL_STEP_W-1:0]  out_col_step;
  logic signed [pdre_pkg::LINE_STEP_W-1:0] out_line_step;
  logic [pdre_pkg::REF_W-1:0]    out_ref_out;
  logic [pdre_pkg::TARGET_W-1:0] out_target_out;
  logic                    out_last;

  int mismatches;
  int pending;
  int records_seen;

  // sender-side bookkeeping, only used to steer the stimulus and the summary
  int track_line = 0;
  int track_col  = 0;
  int sent_beats = 0;
  int usage_beats = 0;

  position_delta_record_encoder_core #(
    .LINE_BITS (LINE_BITS),
    .COL_BITS  (COL_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_line        (in_line),
    .in_line_keep   (in_line_keep),
    .in_col         (in_col),
    .in_col_keep    (in_col_keep),
    .in_ref_kind    (in_ref_kind),
    .in_target      (in_target),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_col_step   (out_col_step),
    .out_line_step  (out_line_step),
    .out_ref_out    (out_ref_out),
    .out_target_out (out_target_out),
    .out_last       (out_last)
  );

  // Watches both channels, predicts the record stream and compares it.
  pdre_record_check #(
    .LINE_BITS (LINE_BITS),
    .COL_BITS  (COL_BITS)
  ) record_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_line        (in_line),
    .in_line_keep   (in_line_keep),
    .in_col         (in_col),
    .in_col_keep    (in_col_keep),
    .in_ref_kind    (in_ref_kind),
    .in_target      (in_target),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_col_step   (out_col_step),
    .out_line_step  (out_line_step),
    .out_ref_out    (out_ref_out),
    .out_target_out (out_target_out),
    .out_last       (out_last),
    .mismatches     (mismatches),
    .pending        (pending),
    .records_seen   (records_seen)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Present one beat at the current falling edge and hold it until the
  // block takes it. Returns at the falling edge after the accept, with
  // in_valid still high so a following beat is presented without a gap.
  task automatic send_position(logic func, int line, logic line_keep, int col,
                               logic col_keep, logic [pdre_pkg::REF_W-1:0] ref_kind,
                               logic [pdre_pkg::TARGET_W-1:0] target);
    in_func      = func;
    in_line      = line[LINE_BITS-1:0];
    in_line_keep = line_keep;
    in_col       = col[COL_BITS-1:0];
    in_col_keep  = col_keep;
    in_ref_kind  = ref_kind;
    in_target    = target;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (!line_keep) track_line = line;
    if (!col_keep) track_col = col;
    if (func == pdre_pkg::FUNC_ADD_REF) usage_beats++;
    sent_beats++;
    @(negedge clk);
  endtask

  // Receiver: a stall pattern that switches between always-ready, coin flip,
  // mostly-stalled and periodic. Low runs are capped so the watchdog only
  // trips on a real hang.
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left  = 0;
  int          low_run    = 0;
  int          ready_phase = 0;

  always @(negedge clk) begin
    logic want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      ready_phase++;
      case (ready_mode)
        READY_ALWAYS:   want = 1'b1;
        READY_COIN:     want = $urandom_range(0, 1);
        READY_SPARSE:   want = ($urandom_range(0, 3) == 0);
        default:        want = ((ready_phase % 5) < 2);
      endcase
      if (!want && low_run >= MAX_LOW_RUN) want = 1'b1;
      low_run = want ? 0 : low_run + 1;
      out_ready <= want;
    end
  end

  // Watchdog: any cycle with a beat on either channel restarts the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, no beat for %0d cycles, %0d records outstanding",
             $time, quiet, pending);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int   burst, pick, nl, nc;
    logic f, lk, ck;

    // synchronous reset held low, then released at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // ---- directed beats ----
    // zero difference from reset: a single closing record
    send_position(pdre_pkg::FUNC_SET_POS, 0, 1'b0, 0, 1'b0, 8'h00, 32'h0);
    // largest forward jump: 32 split records plus the closing one,
    // column splits run alongside; ref/target must read back as zero
    send_position(pdre_pkg::FUNC_SET_POS, LINE_MAX, 1'b0, COL_MAX, 1'b0, 8'hff,
                  32'hffff_ffff);
    // largest backward jump closed by a usage record
    send_position(pdre_pkg::FUNC_ADD_REF, 0, 1'b0, 0, 1'b0, 8'hff, 32'hffff_ffff);
    // exactly the largest single step: no split
    send_position(pdre_pkg::FUNC_SET_POS, 32767, 1'b0, 127, 1'b0, 8'h00, 32'h0);
    // one past the largest step in both coordinates
    send_position(pdre_pkg::FUNC_ADD_REF, 65535, 1'b0, 255, 1'b0, 8'h5a, 32'ha5a5_a5a5);
    // same, negative: -32768 / -128
    send_position(pdre_pkg::FUNC_SET_POS, 32767, 1'b0, 127, 1'b0, 8'h33, 32'h1234_5678);
    send_position(pdre_pkg::FUNC_SET_POS, 1, 1'b0, 1, 1'b0, 8'h00, 32'h0);
    // line marked unchanged: junk line ignored, column jumps and splits
    send_position(pdre_pkg::FUNC_ADD_REF, 999999, 1'b1, 3000, 1'b0, 8'h01, 32'h0000_0001);
    // column marked unchanged
    send_position(pdre_pkg::FUNC_SET_POS, 70000, 1'b0, COL_MAX, 1'b1, 8'h00, 32'h0);
    // both marked unchanged
    send_position(pdre_pkg::FUNC_ADD_REF, 12345, 1'b1, 77, 1'b1, 8'h80, 32'h8000_0000);
    // zero difference closed by a usage record
    send_position(pdre_pkg::FUNC_ADD_REF, 70000, 1'b0, 3000, 1'b0, 8'h00, 32'h0);
    // line -32768 splits, column -127 fits in the split record exactly
    send_position(pdre_pkg::FUNC_SET_POS, 37232, 1'b0, 2873, 1'b0, 8'h00, 32'h0);
    // line up a long way while column goes down a long way
    send_position(pdre_pkg::FUNC_ADD_REF, LINE_MAX, 1'b0, 0, 1'b0, 8'h7f, 32'h7fff_ffff);
    send_position(pdre_pkg::FUNC_SET_POS, LINE_MAX - 1, 1'b0, COL_MAX, 1'b0, 8'h00, 32'h0);
    send_position(pdre_pkg::FUNC_ADD_REF, 0, 1'b0, COL_MAX, 1'b0, 8'hc3, 32'h3c3c_3c3c);
    send_position(pdre_pkg::FUNC_SET_POS, 0, 1'b0, 0, 1'b0, 8'h00, 32'h0);
    in_valid = 1'b0;

    // drain fully before the random phase
    while (pending != 0) @(negedge clk);

    // ---- random beats ----
    // mostly short moves near the current position, some long jumps that
    // split, some full-range values and some corners
    while (sent_beats < 16 + RANDOM_BEATS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          nl = track_line + $urandom_range(0, 400) - 200;
          nc = track_col + $urandom_range(0, 120) - 60;
        end else if (pick < 78) begin
          nl = track_line + $urandom_range(0, 140000) - 70000;
          nc = track_col + $urandom_range(0, 600) - 300;
        end else if (pick < 93) begin
          nl = $urandom_range(0, LINE_MAX);
          nc = $urandom_range(0, COL_MAX);
        end else begin
          nl = $urandom_range(0, 1) * LINE_MAX;
          nc = $urandom_range(0, 1) * COL_MAX;
        end
        if (nl < 0) nl = 0;
        if (nl > LINE_MAX) nl = LINE_MAX;
        if (nc < 0) nc = 0;
        if (nc > COL_MAX) nc = COL_MAX;
        lk = ($urandom_range(0, 6) == 0);
        ck = ($urandom_range(0, 6) == 0);
        // a kept coordinate carries junk that must be ignored
        if (lk) nl = $urandom_range(0, LINE_MAX);
        if (ck) nc = $urandom_range(0, COL_MAX);
        f = $urandom_range(0, 1) ? pdre_pkg::FUNC_ADD_REF : pdre_pkg::FUNC_SET_POS;
        send_position(f, nl, lk, nc, ck, pdre_pkg::REF_W'($urandom), $urandom);
      end
      in_valid = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // hold off until the block has emitted everything
        while (pending != 0) @(negedge clk);
      end else if (pick >= 30) begin
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
    in_valid = 1'b0;

    // ---- drain and verdict ----
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Covered %0d position beats (%0d closing with usage records), %0d records checked,",
             sent_beats, usage_beats, records_seen);
    $display("including maximal split runs, unchanged marks and bursty input with output stalls.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
